// File: rtl/anti_replay_sequence_window_unit_defines.svh
// Assertion macros used by the checker in arsw_checker.sv.
`ifndef ANTI_REPLAY_SEQUENCE_WINDOW_UNIT_DEFINES_SVH
`define ANTI_REPLAY_SEQUENCE_WINDOW_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define ARSW_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("arsw assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is high.
`define ARSW_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("arsw assertion failed (next cycle)");

// Next-cycle implication that also holds through reset.
`define ARSW_ASSERT_NXT_ALWAYS(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("arsw assertion failed (through reset)");

`endif

// File: rtl/arsw_pkg.sv
package arsw_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 64;
  localparam int unsigned SESSION_W       = 64;
  localparam int unsigned SEQ_W           = 32;

  typedef enum logic {
    KIND_CHECK = 1'b0,
    KIND_CLEAR = 1'b1
  } kind_t;

  typedef enum logic {
    VERDICT_ACCEPT = 1'b0,
    VERDICT_REJECT = 1'b1
  } verdict_t;

  typedef struct packed {
    kind_t                kind;
    logic [SESSION_W-1:0] session_ident;
    logic [SEQ_W-1:0]     seq_number;
  } req_t;

  typedef struct packed {
    verdict_t verdict;
  } rsp_t;

endpackage

// File: rtl/arsw_req_if.sv
interface arsw_req_if;
  import arsw_pkg::*;

  logic valid;
  logic ready;
  req_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/arsw_rsp_if.sv
interface arsw_rsp_if;
  import arsw_pkg::*;

  logic valid;
  logic ready;
  rsp_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// File: rtl/anti_replay_sequence_window_unit.sv
// Anti-replay sliding window checker for one receive session.
// Channels: req (sink) carries kind, session_ident and seq_number; rsp
// (source) carries one verdict per request, 0 = accept, 1 = reject.
// A clear request empties the window and always answers accept.
// Path: a request taken on req waits in the input register, then moves to the
// result register, whose verdict drives rsp; a result stalled on rsp can hold
// the next request in the input register.
// Throughput: one request per cycle unless rsp stalls; the single window
// update (64-bit session compare, 32-bit subtract and a WINDOW_SIZE-bit shift)
// sits between the input and result registers and sets that figure.
// Stalls: a result waiting on rsp does not block the input register, so one
// more request is taken; req.ready drops only when both registers are full.
// Reset (rst, synchronous): drop both pipeline registers and mark the window
// empty; the first check afterwards adopts its session and is accepted.
// Sequence numbers do not wrap: a smaller number is always older.
module anti_replay_sequence_window_unit #(
  parameter int unsigned WINDOW_SIZE = arsw_pkg::WINDOW_SIZE_DEF
) (
  input logic       clk,
  input logic       rst,
  arsw_req_if.sink  req,
  arsw_rsp_if.source rsp
);
  import arsw_pkg::*;

  // Shift amount width: jumps inside the window fit in this many bits.
  localparam int unsigned SH_W = (WINDOW_SIZE > 1) ? $clog2(WINDOW_SIZE) : 1;
  localparam logic [WINDOW_SIZE-1:0] BIT0 = WINDOW_SIZE'(1);
  localparam logic [SEQ_W-1:0] WIN_LIMIT = SEQ_W'(WINDOW_SIZE);

  // Input register stage.
  logic a_valid;
  req_t a_item;

  // Result register stage.
  logic     b_valid;
  verdict_t b_verdict;

  // Window state.
  logic                   window_valid;
  logic [SESSION_W-1:0]   current_session;
  logic [SEQ_W-1:0]       top_sequence;
  logic [WINDOW_SIZE-1:0] seen_bits;

  logic                   window_valid_next;
  logic [SESSION_W-1:0]   current_session_next;
  logic [SEQ_W-1:0]       top_sequence_next;
  logic [WINDOW_SIZE-1:0] seen_bits_next;
  verdict_t               verdict_next;

  logic                   advance;
  logic                   same_session;
  logic                   is_newer;
  logic [SEQ_W-1:0]       jump;
  logic [SEQ_W-1:0]       age;
  logic [WINDOW_SIZE-1:0] age_bit;

  // Move the input register into the result register whenever the result
  // register is free or being drained this cycle.
  assign advance   = a_valid && (!b_valid || rsp.ready);
  assign req.ready = !a_valid || advance;

  assign rsp.valid        = b_valid;
  assign rsp.data.verdict = b_verdict;

  assign same_session = window_valid && (current_session == a_item.session_ident);
  assign is_newer     = a_item.seq_number > top_sequence;
  assign jump         = a_item.seq_number - top_sequence;
  assign age          = top_sequence - a_item.seq_number;
  assign age_bit      = BIT0 << age[SH_W-1:0];

  always_comb begin
    window_valid_next    = window_valid;
    current_session_next = current_session;
    top_sequence_next    = top_sequence;
    seen_bits_next       = seen_bits;
    verdict_next         = VERDICT_ACCEPT;

    priority if (a_item.kind == KIND_CLEAR) begin
      // Empty the window; the other fields are stale until adopted again.
      window_valid_next = 1'b0;
    end else if (!same_session) begin
      // Adopt a new session with only its own sequence marked.
      window_valid_next    = 1'b1;
      current_session_next = a_item.session_ident;
      top_sequence_next    = a_item.seq_number;
      seen_bits_next       = BIT0;
    end else if (is_newer) begin
      // Slide the window forward; a jump past its end leaves only bit 0.
      top_sequence_next = a_item.seq_number;
      if (jump >= WIN_LIMIT) begin
        seen_bits_next = BIT0;
      end else begin
        seen_bits_next = (seen_bits << jump[SH_W-1:0]) | BIT0;
      end
    end else if (age >= WIN_LIMIT) begin
      verdict_next = VERDICT_REJECT;
    end else if ((seen_bits & age_bit) != '0) begin
      verdict_next = VERDICT_REJECT;
    end else begin
      seen_bits_next = seen_bits | age_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid      <= 1'b0;
      b_valid      <= 1'b0;
      window_valid <= 1'b0;
    end else begin
      if (req.ready) begin
        a_valid <= req.valid;
      end
      if (advance) begin
        b_valid      <= 1'b1;
        window_valid <= window_valid_next;
      end else if (rsp.ready) begin
        b_valid <= 1'b0;
      end
    end
  end

  // Payload registers: no reset needed.
  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      a_item <= req.data;
    end
    if (advance) begin
      b_verdict       <= verdict_next;
      current_session <= current_session_next;
      top_sequence    <= top_sequence_next;
      seen_bits       <= seen_bits_next;
    end
  end

endmodule

// File: rtl/arsw_checker.sv
`include "anti_replay_sequence_window_unit_defines.svh"

module arsw_checker (
  input logic clk,
  input logic rst,
  input logic req_valid,
  input logic req_ready,
  input logic req_kind,
  input logic rsp_valid,
  input logic rsp_ready,
  input logic rsp_verdict
);
  import arsw_pkg::*;

  logic req_xfer;
  logic clear_in;

  assign req_xfer = req_valid && req_ready;
  assign clear_in = req_xfer && (req_kind == KIND_CLEAR) && !rsp_valid;

  // No result may survive reset.
  `ARSW_ASSERT_NXT_ALWAYS(a_rst_empty, clk, rst, !rsp_valid)

  // A stalled result holds.
  `ARSW_ASSERT_NXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_verdict))

  // With no result pending the input register can move on, so requests are taken.
  `ARSW_ASSERT_IMP(a_ready_when_empty, clk, rst, !rsp_valid, req_ready)

  // An idle cycle with no result empties the input register; a clear taken right
  // after it with no result pending passes both registers and answers accept.
  `ARSW_ASSERT_NXT(a_clear_accepts, clk, rst, (!rsp_valid && !req_xfer) ##1 clear_in, ##1 (rsp_valid && (rsp_verdict == VERDICT_ACCEPT)))

endmodule

bind anti_replay_sequence_window_unit arsw_checker u_arsw_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .req_kind    (req.data.kind),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_verdict (rsp.data.verdict)
);

// File: bench/anti_replay_sequence_window_unit_test.sv
// Bench for the anti-replay window unit.
//
// A request stream of check and clear transfers runs through the unit. Every
// accepted transfer is also run through a local copy of the window (session,
// highest sequence, seen bits), and the verdict that copy gives is queued.
// Each verdict transfer on the response side is compared with the oldest
// queued verdict.
//
// Inputs change on the falling edge; handshakes and outputs are sampled on
// the rising edge.
module anti_replay_sequence_window_unit_test;
  import arsw_pkg::*;

  localparam int unsigned WIN         = WINDOW_SIZE_DEF;
  localparam logic [63:0] WIN_MASK    = {64{1'b1}} >> (64 - WIN);
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned TAIL_CYCLES = 8;

  // One queued verdict, with the request that caused it for reporting.
  typedef struct {
    req_t     item;
    verdict_t verdict;
  } verdict_rec_t;

  logic clk;
  logic rst;

  arsw_req_if req();
  arsw_rsp_if rsp();

  anti_replay_sequence_window_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  // Local copy of the window state.
  logic                 win_valid;
  logic [SESSION_W-1:0] cur_session;
  logic [SEQ_W-1:0]     top_seq;
  logic [63:0]          mirror_bits;

  verdict_rec_t pending_verdicts[$];

  // Idle rates in percent: sender gaps and receiver stalls.
  int send_idle_pct;
  int recv_stall_pct;

  int          packets_sent;
  int          clears_sent;
  int          verdicts_checked;
  int          rejects_seen;
  int          mismatches;
  int unsigned cycle_count;

  logic [SESSION_W-1:0] session_pool [4];

  // Clock: period 8.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Time out a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d verdicts outstanding", $time,
               cycle_count, pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Drive the response ready: stall at the current rate, change only on the
  // falling edge.
  initial begin
    rsp.ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp.ready <= (rst == 1'b0) && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Work out the verdict for one request and advance the local window.
  function automatic verdict_t judge_packet(req_t item);
    logic [SEQ_W-1:0] gap;

    if (item.kind == KIND_CLEAR) begin
      win_valid   = 1'b0;
      cur_session = '0;
      top_seq     = '0;
      mirror_bits = '0;
      return VERDICT_ACCEPT;
    end
    // Empty window or another session: adopt the packet.
    if (!win_valid || cur_session != item.session_ident) begin
      win_valid   = 1'b1;
      cur_session = item.session_ident;
      top_seq     = item.seq_number;
      mirror_bits = 64'd1;
      return VERDICT_ACCEPT;
    end
    // Newer packet: slide the window forward.
    if (item.seq_number > top_seq) begin
      gap = item.seq_number - top_seq;
      if (gap >= WIN) mirror_bits = 64'd1;
      else mirror_bits = ((mirror_bits << gap) | 64'd1) & WIN_MASK;
      top_seq = item.seq_number;
      return VERDICT_ACCEPT;
    end
    // Older or equal packet: reject if too old or already seen.
    gap = top_seq - item.seq_number;
    if (gap >= WIN) return VERDICT_REJECT;
    if (mirror_bits[gap[5:0]]) return VERDICT_REJECT;
    mirror_bits[gap[5:0]] = 1'b1;
    return VERDICT_ACCEPT;
  endfunction

  // Check every verdict transfer against the oldest queued verdict.
  always @(posedge clk) begin
    verdict_rec_t exp_rec;
    if (!rst && rsp.valid && rsp.ready) begin
      verdicts_checked++;
      if (rsp.data.verdict == VERDICT_REJECT) rejects_seen++;
      if (pending_verdicts.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected verdict transfer: expected none, actual %0d",
                 $time, rsp.data.verdict);
      end else begin
        exp_rec = pending_verdicts.pop_front();
        if (rsp.data.verdict !== exp_rec.verdict) begin
          mismatches++;
          $display("%0t: verdict mismatch (kind %0d session %h seq %h): expected %0d, actual %0d",
                   $time, exp_rec.item.kind, exp_rec.item.session_ident,
                   exp_rec.item.seq_number, exp_rec.verdict, rsp.data.verdict);
        end
      end
    end
  end

  // Send one request. Entered and left on a falling edge; valid stays high on
  // return so that back-to-back transfers need no extra assignment.
  task automatic send_item(kind_t kind, logic [SESSION_W-1:0] sess, logic [SEQ_W-1:0] seq);
    req_t         item;
    verdict_rec_t rec;

    item.kind          = kind;
    item.session_ident = sess;
    item.seq_number    = seq;
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.data  <= item;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    // Transfer taken at this edge: predict it now.
    rec.item    = item;
    rec.verdict = judge_packet(item);
    pending_verdicts.push_back(rec);
    packets_sent++;
    if (kind == KIND_CLEAR) clears_sent++;
    @(negedge clk);
  endtask

  // Hold the sender until every queued verdict has come back.
  task automatic hold_until_drained();
    req.valid <= 1'b0;
    @(negedge clk);
    while (pending_verdicts.size() != 0) @(negedge clk);
  endtask

  // Adopt on an empty window, then a repeat of the highest sequence, a step
  // forward and a repeat of an older one already seen.
  task automatic test_adopt_and_repeat();
    send_item(KIND_CHECK, 64'd0, 32'd0);
    send_item(KIND_CHECK, 64'd0, 32'd0);
    send_item(KIND_CHECK, 64'd0, 32'd1);
    send_item(KIND_CHECK, 64'd0, 32'd0);
  endtask

  // Window edges: jumps of WIN-1 and WIN, distances of WIN-1 and WIN.
  task automatic test_window_edges();
    logic [SESSION_W-1:0] sess;

    sess = 64'hA5A5_5A5A_C3C3_3C3C;
    send_item(KIND_CHECK, sess, 32'd1000);
    send_item(KIND_CHECK, sess, 32'd1000 + WIN - 1);
    send_item(KIND_CHECK, sess, 32'd1000);
    send_item(KIND_CHECK, sess, 32'd999);
    send_item(KIND_CHECK, sess, 32'd1001);
    send_item(KIND_CHECK, sess, 32'd1000 + 2 * WIN - 1);
    send_item(KIND_CHECK, sess, 32'd1000 + WIN - 1);
    send_item(KIND_CHECK, sess, 32'd1000 + WIN);
  endtask

  // Extreme field values and a session switch.
  task automatic test_extreme_fields();
    send_item(KIND_CHECK, {SESSION_W{1'b1}}, {SEQ_W{1'b1}});
    send_item(KIND_CHECK, {SESSION_W{1'b1}}, {SEQ_W{1'b1}} - (WIN - 1));
    send_item(KIND_CHECK, {SESSION_W{1'b1}}, 32'd0);
    send_item(KIND_CHECK, 64'd0, {SEQ_W{1'b1}});
  endtask

  // Clear with junk fields, clear on an empty window, adopt after a clear.
  task automatic test_clear();
    send_item(KIND_CLEAR, {SESSION_W{1'b1}}, {SEQ_W{1'b1}});
    send_item(KIND_CHECK, 64'd0, 32'h8000_0000);
    send_item(KIND_CLEAR, 64'd0, 32'd0);
    send_item(KIND_CLEAR, 64'h0123_4567_89AB_CDEF, 32'h5555_AAAA);
    send_item(KIND_CHECK, 64'd0, 32'd5);
  endtask

  // Random traffic: mostly packets of a live session near its highest
  // sequence, with session switches, clears and random noise mixed in.
  task automatic run_traffic(int count, int send_pct, int stall_pct);
    int                   pick;
    int                   delta;
    longint               next_seq;
    logic [SESSION_W-1:0] sess;
    logic [SEQ_W-1:0]     seq;

    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 3) begin
        send_item(KIND_CLEAR, {$urandom, $urandom}, $urandom);
      end else if (pick < 8) begin
        send_item(KIND_CHECK, {$urandom, $urandom}, $urandom);
      end else if (pick < 12 || !win_valid) begin
        // Switch to a pooled session; refresh the pool entry now and then.
        pick = $urandom_range(3);
        if ($urandom_range(99) < 30) session_pool[pick] = {$urandom, $urandom};
        send_item(KIND_CHECK, session_pool[pick], $urandom);
      end else begin
        sess = cur_session;
        pick = $urandom_range(99);
        if (pick < 95) begin
          if (pick < 40) delta = $urandom_range(8, 1);
          else if (pick < 50) delta = $urandom_range(100, 9);
          else begin
            delta = $urandom_range(70, 0);
            delta = -delta;
          end
          next_seq = longint'(top_seq) + delta;
          if (next_seq < 0) next_seq = 0;
          if (next_seq > 64'hFFFF_FFFF) next_seq = 64'hFFFF_FFFF;
          seq = next_seq[SEQ_W-1:0];
        end else begin
          seq = $urandom;
        end
        send_item(KIND_CHECK, sess, seq);
      end
      // Pause now and then until the unit has answered everything.
      if (i % 300 == 299) hold_until_drained();
    end
  endtask

  initial begin
    rst            = 1'b1;
    req.valid      = 1'b0;
    req.data       = '0;
    win_valid      = 1'b0;
    cur_session    = '0;
    top_seq        = '0;
    mirror_bits    = '0;
    send_idle_pct  = 17;
    recv_stall_pct = 61;
    packets_sent     = 0;
    clears_sent      = 0;
    verdicts_checked = 0;
    rejects_seen     = 0;
    mismatches       = 0;
    cycle_count      = 0;
    foreach (session_pool[k]) session_pool[k] = {$urandom, $urandom};

    // Hold reset, then release it on a falling edge.
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_adopt_and_repeat();
    test_window_edges();
    test_extreme_fields();
    test_clear();
    hold_until_drained();

    run_traffic(640, 17, 61);
    run_traffic(640, 61, 17);
    run_traffic(620, 0, 0);

    // Drain, then watch on through the tail for stray verdicts.
    hold_until_drained();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d clears); checked %0d verdicts, %0d rejects.",
             packets_sent, clears_sent, verdicts_checked, rejects_seen);
    $display("Covered window edges, session switches, clears and three idle mixes.");
    if (mismatches == 0 && pending_verdicts.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("%0t: %0d mismatches, %0d verdicts never arrived", $time, mismatches,
               pending_verdicts.size());
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/arsw_pkg.sv
rtl/arsw_req_if.sv
rtl/arsw_rsp_if.sv
rtl/anti_replay_sequence_window_unit.sv
rtl/arsw_checker.sv
bench/anti_replay_sequence_window_unit_test.sv
